// ===== rtl/rxs_pkg.sv =====
// ----------------------------------------------------------------------------
// rxs_pkg
// Shared types, constants and register codes of the rolling xor scrambler.
// ----------------------------------------------------------------------------
package rxs_pkg;

	// default sizes
	localparam int unsigned STRING_DEPTH_DEF  = 1024;
	localparam int unsigned ENCODE_HEADER_DEF = 12;
	localparam int unsigned QUEUE_DEPTH       = 2;

	// field widths fixed by the stream format
	localparam int unsigned POS_W = 16;

	// position handling
	localparam logic [POS_W-1:0] POS_MIX      = 16'd4;
	localparam logic [POS_W-1:0] POS_MAX      = 16'hFFFF;
	localparam logic [POS_W-1:0] POS_WRAP     = 16'h8000;
	localparam logic [5:0]       DEC_SKIP_MIN = 6'd4;

	// key character handling
	localparam logic [7:0] CHAR_DOT     = 8'h2E;
	localparam logic [7:0] CHAR_PERCENT = 8'h25;
	localparam logic [7:0] CHAR_MAX     = 8'h7F;

	// operation codes
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_BYTE = 1'b1;

	// register indexes
	localparam logic [1:0] REG_CHALLENGE = 2'd0;
	localparam logic [1:0] REG_ENCODE    = 2'd1;
	localparam logic [1:0] REG_PERCENT   = 2'd2;
	localparam logic [1:0] REG_DEC_SKIP  = 2'd3;

	// register reset values
	localparam logic [7:0] CHALLENGE_RST = 8'd0;
	localparam logic       ENCODE_RST    = 1'b1;
	localparam logic       PERCENT_RST   = 1'b0;
	localparam logic [5:0] DEC_SKIP_RST  = 6'd8;

	typedef struct packed {
		logic       op;
		logic [7:0] data_in;
		logic       first_in;
		logic       last_in;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] data_out;
		logic       last_out;
	} out_beat_t;

	typedef struct packed {
		logic [7:0] challenge_low;
		logic       encode_mode;
		logic       percent_subst;
		logic [5:0] decode_skip;
	} cfg_t;

	// classified item handed from front to back
	typedef struct packed {
		logic       is_load;
		logic [7:0] data;
		logic       first;
		logic       last;
		logic       reseed;
		logic       mix4;
		logic       scramble;
		logic       parity;
	} work_t;

endpackage

// ===== rtl/rxs_front.sv =====
// ----------------------------------------------------------------------------
// rxs_front
// Accepts input beats, tracks the message byte position and classifies each
// byte as header, reseed, seed mix or scrambled.
// ----------------------------------------------------------------------------
module rxs_front #(
	parameter int unsigned ENCODE_HEADER = rxs_pkg::ENCODE_HEADER_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  rxs_pkg::in_beat_t in_beat,
	input  rxs_pkg::cfg_t    cfg,
	output logic             push,
	output rxs_pkg::work_t   push_item,
	input  logic             queue_full
);

	logic [rxs_pkg::POS_W-1:0] pos_q;
	logic [rxs_pkg::POS_W-1:0] pos;
	logic [rxs_pkg::POS_W-1:0] header;
	logic [5:0]                skip;
	logic                      accept;

	assign in_stall = queue_full;
	assign accept   = in_valid && !queue_full;
	assign push     = accept;

	// header length from the mode
	always_comb begin
		skip = (cfg.decode_skip < rxs_pkg::DEC_SKIP_MIN) ? rxs_pkg::DEC_SKIP_MIN
			: cfg.decode_skip;
		if (cfg.encode_mode) begin
			header = rxs_pkg::POS_W'(ENCODE_HEADER);
		end else begin
			header = {{(rxs_pkg::POS_W-6){1'b0}}, skip};
		end
	end

	assign pos = in_beat.first_in ? '0 : pos_q;

	// classify the beat
	always_comb begin
		push_item.is_load  = (in_beat.op == rxs_pkg::OP_LOAD);
		push_item.data     = in_beat.data_in;
		push_item.first    = in_beat.first_in;
		push_item.last     = in_beat.last_in;
		push_item.reseed   = (pos == '0);
		push_item.mix4     = cfg.encode_mode && (pos == rxs_pkg::POS_MIX);
		push_item.scramble = (pos >= header);
		push_item.parity   = pos[0];
	end

	// byte position counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept && in_beat.op == rxs_pkg::OP_BYTE) begin
			if (in_beat.last_in) begin
				pos_q <= '0;
			end else if (pos == rxs_pkg::POS_MAX) begin
				pos_q <= rxs_pkg::POS_WRAP;
			end else begin
				pos_q <= pos + 1'b1;
			end
		end
	end

endmodule

// ===== rtl/rxs_queue.sv =====
// ----------------------------------------------------------------------------
// rxs_queue
// Short register queue of classified items between front and back.
// ----------------------------------------------------------------------------
module rxs_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  rxs_pkg::work_t push_item,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output rxs_pkg::work_t head_item
);

	localparam int unsigned PW = (rxs_pkg::QUEUE_DEPTH > 1) ? $clog2(rxs_pkg::QUEUE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(rxs_pkg::QUEUE_DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(rxs_pkg::QUEUE_DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(rxs_pkg::QUEUE_DEPTH);

	rxs_pkg::work_t slot_q [rxs_pkg::QUEUE_DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign full       = (count_q == CNT_FULL);
	assign head_valid = (count_q != '0);
	assign head_item  = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/rxs_back.sv =====
// ----------------------------------------------------------------------------
// rxs_back
// Holds the key string store, the string index and the running key, and
// produces one output beat per message byte into an output register.
// ----------------------------------------------------------------------------
module rxs_back #(
	parameter int unsigned STRING_DEPTH = rxs_pkg::STRING_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  rxs_pkg::work_t    head_item,
	output logic              pop,
	input  rxs_pkg::cfg_t     cfg,
	output logic              out_valid,
	input  logic              out_stall,
	output rxs_pkg::out_beat_t out_beat
);

	localparam int unsigned IW = $clog2(STRING_DEPTH);
	localparam int unsigned LW = $clog2(STRING_DEPTH + 1);
	localparam logic [LW-1:0] LEN_FULL = LW'(STRING_DEPTH);

	logic [7:0]    mem [STRING_DEPTH];
	logic [IW-1:0] idx_q;
	logic [LW-1:0] len_q;
	logic [7:0]    rd_q;
	logic [7:0]    char0_q;
	logic [7:0]    key_q;
	logic          out_valid_q;
	rxs_pkg::out_beat_t out_q;

	logic          go;
	logic          wrap;
	logic [IW-1:0] eff_idx;
	logic [7:0]    cur;
	logic [7:0]    raw;
	logic [7:0]    ch;
	logic [7:0]    shifted;
	logic [LW-1:0] nxt;
	logic [IW-1:0] next_idx;
	logic [IW-1:0] idx_d;
	logic          we;
	logic [IW-1:0] waddr;
	logic [7:0]    seed_key;
	logic [7:0]    key_d;

	assign out_valid = out_valid_q;
	assign out_beat  = out_q;

	// one item per cycle while the output register has room; loads need no output room
	assign go  = head_valid && (head_item.is_load || !out_valid_q || !out_stall);
	assign pop = go;

	// key character fetch with wrap at string end or zero character
	always_comb begin
		wrap     = (LW'(idx_q) >= len_q) || (rd_q == 8'd0);
		eff_idx  = wrap ? '0 : idx_q;
		cur      = wrap ? char0_q : rd_q;
		raw      = (len_q != '0) ? cur : 8'd0;
		nxt      = LW'(eff_idx) + 1'b1;
		next_idx = (nxt >= len_q) ? '0 : nxt[IW-1:0];
		if (raw > rxs_pkg::CHAR_MAX
			|| (raw == rxs_pkg::CHAR_PERCENT && cfg.percent_subst)) begin
			ch = rxs_pkg::CHAR_DOT;
		end else begin
			ch = raw;
		end
		shifted = head_item.parity ? {ch[6:0], 1'b0} : ch;
	end

	// store write for loads
	always_comb begin
		waddr = head_item.first ? '0 : len_q[IW-1:0];
		we    = go && head_item.is_load && (head_item.first || len_q < LEN_FULL);
	end

	// running key update
	always_comb begin
		if (head_item.reseed) begin
			seed_key = cfg.challenge_low ^ head_item.data;
		end else if (head_item.mix4) begin
			seed_key = key_q ^ head_item.data;
		end else begin
			seed_key = key_q;
		end
		key_d = head_item.scramble ? (seed_key ^ shifted) : seed_key;
	end

	// next string index
	always_comb begin
		idx_d = idx_q;
		if (go && !head_item.is_load) begin
			if (head_item.reseed) begin
				idx_d = '0;
			end else if (head_item.scramble) begin
				idx_d = next_idx;
			end
		end
	end

	// key string store, read data tracks the next index
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= head_item.data;
		end
		if (we && waddr == idx_d) begin
			rd_q <= head_item.data;
		end else begin
			rd_q <= mem[idx_d];
		end
		if (we && waddr == '0) begin
			char0_q <= head_item.data;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (go && !head_item.is_load) begin
			out_q.data_out <= head_item.scramble ? (head_item.data ^ key_d) : head_item.data;
			out_q.last_out <= head_item.last;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			len_q       <= '0;
			key_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			idx_q <= idx_d;
			if (we) begin
				len_q <= LW'(waddr) + 1'b1;
			end
			if (go && !head_item.is_load) begin
				key_q       <= key_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/rolling_xor_stream_scrambler.sv =====
// ----------------------------------------------------------------------------
// rolling_xor_stream_scrambler
// Rolling xor key scrambler for a message byte stream with a loadable key
// string.
//
//   channel  direction  payload      handshake
//   in       input      in_beat_t    in_valid / in_stall
//   out      output     out_beat_t   out_valid / out_stall
//   cfg      input      cfg_data     cfg_we, cfg_index
//
// one beat per cycle sustained while out_stall stays low; a message byte passes
// through the queue, then the output register, and a load leaves nothing.
// the rate is set by the key store read, issued each cycle at the next index.
// reset clears control state at once; the key store is not cleared.
// in_stall rises only when the two-entry queue is full, so each side stalls
// on its own.
// ----------------------------------------------------------------------------
module rolling_xor_stream_scrambler #(
	parameter int unsigned STRING_DEPTH  = rxs_pkg::STRING_DEPTH_DEF,
	parameter int unsigned ENCODE_HEADER = rxs_pkg::ENCODE_HEADER_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  rxs_pkg::in_beat_t  in_beat,
	output logic               out_valid,
	input  logic               out_stall,
	output rxs_pkg::out_beat_t out_beat,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [7:0]         cfg_data
);

	rxs_pkg::cfg_t  cfg_q;
	logic           push;
	rxs_pkg::work_t push_item;
	logic           queue_full;
	logic           pop;
	logic           head_valid;
	rxs_pkg::work_t head_item;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.challenge_low <= rxs_pkg::CHALLENGE_RST;
			cfg_q.encode_mode   <= rxs_pkg::ENCODE_RST;
			cfg_q.percent_subst <= rxs_pkg::PERCENT_RST;
			cfg_q.decode_skip   <= rxs_pkg::DEC_SKIP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				rxs_pkg::REG_CHALLENGE: cfg_q.challenge_low <= cfg_data;
				rxs_pkg::REG_ENCODE:    cfg_q.encode_mode   <= cfg_data[0];
				rxs_pkg::REG_PERCENT:   cfg_q.percent_subst <= cfg_data[0];
				rxs_pkg::REG_DEC_SKIP:  cfg_q.decode_skip   <= cfg_data[5:0];
				default: begin
				end
			endcase
		end
	end

	// front: accept and classify
	rxs_front #(
		.ENCODE_HEADER(ENCODE_HEADER)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_beat   (in_beat),
		.cfg       (cfg_q),
		.push      (push),
		.push_item (push_item),
		.queue_full(queue_full)
	);

	// queue between front and back
	rxs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (queue_full),
		.pop       (pop),
		.head_valid(head_valid),
		.head_item (head_item)
	);

	// back: key store, key update, output register
	rxs_back #(
		.STRING_DEPTH(STRING_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head_item (head_item),
		.pop       (pop),
		.cfg       (cfg_q),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_beat  (out_beat)
	);

endmodule

// ===== dv/tb_rolling_xor_stream_scrambler.sv =====
// ----------------------------------------------------------------------------
// tb_rolling_xor_stream_scrambler
// Self-checking bench for the rolling xor stream scrambler. Key strings and
// message bytes go in through the valid/stall input channel. Each beat that
// is taken updates a cycle-free model of the key string, the rolling key and
// the byte position. Every output beat that leaves is compared in order
// against that model. The run covers directed corner cases first, then three
// random pacing mixes.
// ----------------------------------------------------------------------------
module tb_rolling_xor_stream_scrambler;
	timeunit 1ns;
	timeprecision 1ps;

	import rxs_pkg::*;

	localparam int CYCLE_LIMIT    = 400000;

	// model of the key string, rolling key and position, plus expected bytes
	class keystream_tracker;
		logic [7:0]  key_mem [STRING_DEPTH_DEF];
		logic [10:0] key_len;
		logic [9:0]  key_idx;
		logic [7:0]  roll_key;
		logic [15:0] byte_pos;
		cfg_t        regs;
		out_beat_t   pending_bytes [$];
		int          n_bad;
		int          n_checked;
		int          n_chars;
		int          n_bytes;

		function new();
			key_len = '0;
			key_idx = '0;
			roll_key = '0;
			byte_pos = '0;
			regs.challenge_low = CHALLENGE_RST;
			regs.encode_mode = ENCODE_RST;
			regs.percent_subst = PERCENT_RST;
			regs.decode_skip = DEC_SKIP_RST;
			n_bad = 0;
			n_checked = 0;
			n_chars = 0;
			n_bytes = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [7:0] val);
			case (idx)
				REG_CHALLENGE: regs.challenge_low = val;
				REG_ENCODE:    regs.encode_mode = val[0];
				REG_PERCENT:   regs.percent_subst = val[0];
				REG_DEC_SKIP:  regs.decode_skip = val[5:0];
				default: ;
			endcase
		endfunction

		// next key character, wrapping at the length or at a zero character
		function logic [7:0] next_key_char();
			logic [7:0] c;
			if (key_idx >= key_len || key_mem[key_idx] == 8'h00)
				key_idx = '0;
			c = (key_len != 0) ? key_mem[key_idx] : 8'h00;
			key_idx = key_idx + 1'b1;
			if (key_idx >= key_len)
				key_idx = '0;
			if (c > CHAR_MAX || (c == CHAR_PERCENT && regs.percent_subst))
				c = CHAR_DOT;
			return c;
		endfunction

		// note one accepted input beat
		function void take_beat(in_beat_t b);
			logic [15:0] pos;
			logic [7:0]  c;
			logic [7:0]  res;
			int          hdr;
			out_beat_t   e;
			if (b.op == OP_LOAD) begin
				n_chars++;
				if (b.first_in)
					key_len = '0;
				if (key_len < STRING_DEPTH_DEF) begin
					key_mem[key_len] = b.data_in;
					key_len = key_len + 1'b1;
				end
				return;
			end
			n_bytes++;
			pos = b.first_in ? '0 : byte_pos;
			if (regs.encode_mode)
				hdr = ENCODE_HEADER_DEF;
			else
				hdr = (regs.decode_skip < DEC_SKIP_MIN) ? DEC_SKIP_MIN : regs.decode_skip;
			res = b.data_in;
			// reseed at message start, mix the byte at position four in encode mode
			if (pos == 0) begin
				roll_key = regs.challenge_low ^ b.data_in;
				key_idx = '0;
			end else if (regs.encode_mode && pos == POS_MIX) begin
				roll_key = roll_key ^ b.data_in;
			end
			if (pos >= hdr) begin
				c = next_key_char();
				roll_key = roll_key ^ (pos[0] ? {c[6:0], 1'b0} : c);
				res = b.data_in ^ roll_key;
			end
			if (b.last_in)
				byte_pos = '0;
			else if (pos == POS_MAX)
				byte_pos = POS_WRAP;
			else
				byte_pos = pos + 1'b1;
			e.data_out = res;
			e.last_out = b.last_in;
			pending_bytes.push_back(e);
		endfunction

		task report(string msg);
			$display("[%0t] mismatch: %s", $time, msg);
			n_bad++;
		endtask

		// compare one output beat with the oldest expected byte
		task check_byte(out_beat_t got);
			out_beat_t e;
			if (pending_bytes.size() == 0) begin
				report($sformatf("output beat %0h/%0b with nothing expected",
					got.data_out, got.last_out));
				return;
			end
			e = pending_bytes.pop_front();
			n_checked++;
			if (got.data_out !== e.data_out)
				report($sformatf("data_out %0h, expected %0h (beat %0d)",
					got.data_out, e.data_out, n_checked));
			if (got.last_out !== e.last_out)
				report($sformatf("last_out %0b, expected %0b (beat %0d)",
					got.last_out, e.last_out, n_checked));
		endtask
	endclass

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	in_beat_t   in_beat;
	logic       out_valid;
	logic       out_stall = 1'b0;
	out_beat_t  out_beat;
	logic       cfg_we;
	logic [1:0] cfg_index;
	logic [7:0] cfg_data;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int cycles = 0;
	int beats_sent = 0;
	keystream_tracker trk;

	rolling_xor_stream_scrambler i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_beat   (in_beat),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_beat  (out_beat),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #10 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("run limit of %0d cycles reached", CYCLE_LIMIT);
			$display("FAILURE");
			$finish;
		end
	end

	// receiver back-pressure
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// output beat checking
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			trk.check_byte(out_beat);
	end

	// drive one beat and hold it until taken
	task automatic send_beat(in_beat_t b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_beat <= b;
		do @(posedge clk); while (in_stall);
		trk.take_beat(b);
		beats_sent++;
		@(negedge clk);
	endtask

	// stop sending and wait until every expected byte has left
	task automatic drain_bytes();
		in_valid <= 1'b0;
		while (trk.pending_bytes.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// write all four registers back to back
	task automatic program_regs(logic [7:0] chal, logic [7:0] enc, logic [7:0] pct,
			logic [7:0] skip);
		logic [1:0] ids [4];
		logic [7:0] vals [4];
		ids = '{REG_CHALLENGE, REG_ENCODE, REG_PERCENT, REG_DEC_SKIP};
		vals = '{chal, enc, pct, skip};
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= ids[i];
			cfg_data <= vals[i];
			trk.write_reg(ids[i], vals[i]);
			@(negedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	// random settings biased toward the extremes; unused upper bits are noise
	task automatic program_random_regs();
		logic [7:0] chal;
		logic [7:0] skip;
		case ($urandom_range(3))
			0: chal = 8'h00;
			1: chal = 8'hFF;
			default: chal = 8'($urandom);
		endcase
		case ($urandom_range(5))
			0: skip = 8'($urandom_range(0, 3));
			1: skip = 8'd63;
			2, 3: skip = 8'($urandom_range(4, 16));
			default: skip = 8'($urandom_range(4, 63));
		endcase
		skip[7:6] = 2'($urandom_range(3));
		program_regs(chal, {7'($urandom), 1'($urandom_range(1))},
			{7'($urandom), 1'($urandom_range(1))}, skip);
	endtask

	function automatic logic [7:0] pick_key_char(bit nonzero);
		int         r;
		logic [7:0] c;
		r = $urandom_range(99);
		if (r < 55)
			c = 8'($urandom_range(8'h20, 8'h7E));
		else if (r < 67)
			c = CHAR_PERCENT;
		else if (r < 82)
			c = 8'($urandom_range(8'h80, 8'hFF));
		else if (r < 87)
			c = 8'h00;
		else
			c = 8'($urandom);
		if (nonzero && c == 8'h00)
			c = 8'h01;
		return c;
	endfunction

	task automatic send_key_string(int len, bit with_first, bit nonzero);
		in_beat_t b;
		for (int i = 0; i < len; i++) begin
			b = '0;
			b.op = OP_LOAD;
			b.data_in = pick_key_char(nonzero);
			b.first_in = with_first && i == 0;
			b.last_in = 1'($urandom_range(1));
			send_beat(b);
		end
	endtask

	// message beats; noise_pct of them get random op and markers
	task automatic send_message(int len, bit with_first, bit with_last, int noise_pct);
		in_beat_t b;
		for (int i = 0; i < len; i++) begin
			b = '0;
			b.op = OP_BYTE;
			case ($urandom_range(19))
				0: b.data_in = 8'h00;
				1: b.data_in = 8'hFF;
				default: b.data_in = 8'($urandom);
			endcase
			b.first_in = with_first && i == 0;
			b.last_in = with_last && i == len - 1;
			if ($urandom_range(99) < noise_pct) begin
				b.op = 1'($urandom_range(1));
				b.first_in = 1'($urandom_range(1));
				b.last_in = 1'($urandom_range(1));
			end
			send_beat(b);
		end
	endtask

	task automatic run_directed();
		logic [7:0] short_msg [6];
		logic [7:0] key_chars [6];
		in_beat_t   b;
		short_msg = '{8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h80, 8'h7F};
		key_chars = '{CHAR_PERCENT, 8'hFF, 8'h80, 8'h41, 8'h00, 8'h5A};
		// decode, header clamped up to four, percent swap, all-ones challenge
		program_regs(8'hFF, 8'hFE, 8'h01, 8'hC0);
		// message against an empty key string
		for (int i = 0; i < 6; i++) begin
			b = '0;
			b.op = OP_BYTE;
			b.data_in = short_msg[i];
			b.first_in = (i == 0);
			b.last_in = (i == 5);
			send_beat(b);
		end
		// key string with a percent, high characters and an embedded zero
		for (int i = 0; i < 6; i++) begin
			b = '0;
			b.op = OP_LOAD;
			b.data_in = key_chars[i];
			b.first_in = (i == 0);
			b.last_in = (i == 3);
			send_beat(b);
		end
		// message right after a last beat, without a first mark
		for (int i = 0; i < 12; i++) begin
			b = '0;
			b.op = OP_BYTE;
			b.data_in = 8'(i * 8'h35 + 8'h0F);
			b.last_in = (i == 11);
			send_beat(b);
		end
		drain_bytes();
	endtask

	task automatic random_phase(int s_pct, int r_pct, int n_items);
		int start;
		int pick;
		int len;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		drain_bytes();
		program_random_regs();
		start = beats_sent;
		while (beats_sent - start < n_items) begin
			pick = $urandom_range(99);
			if (pick < 10) begin
				drain_bytes();
				program_random_regs();
			end else if (pick < 30) begin
				send_key_string($urandom_range(1, 40), $urandom_range(99) < 90, 1'b0);
			end else begin
				len = ($urandom_range(99) < 75) ? $urandom_range(1, 24) : $urandom_range(25, 80);
				send_message(len, $urandom_range(99) < 85, $urandom_range(99) < 85, 4);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_beat = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		trk = new();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		run_directed();
		random_phase(22, 77, 275);
		random_phase(77, 22, 275);
		random_phase(0, 0, 276);

		drain_bytes();
		repeat (8) @(negedge clk);
		if (trk.pending_bytes.size() != 0)
			trk.report($sformatf("%0d expected bytes never came out",
				trk.pending_bytes.size()));
		$display("sent %0d key characters and %0d message bytes over directed cases",
			trk.n_chars, trk.n_bytes);
		$display("and three pacing mixes; %0d beats checked, %0d bad",
			trk.n_checked, trk.n_bad);
		if (trk.n_bad == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
